/* src/cmc_pkg.sv */
// ----------------------------------------------------------------------------
// cmc_pkg
// Shared types and constants of the CpG methylation counter: beat payloads,
// item kinds, base characters, count categories and the queued operation.
// ----------------------------------------------------------------------------
package cmc_pkg;

  // item kinds
  localparam logic [1:0] KIND_COUNT   = 2'd0;
  localparam logic [1:0] KIND_SITE_RD = 2'd1;
  localparam logic [1:0] KIND_BIAS_RD = 2'd2;

  // bias group that has no table
  localparam logic [1:0] GRP_NONE = 2'd3;
  localparam int NUM_GROUPS = 3;

  // counter categories
  localparam int NUM_CAT = 6;
  localparam logic [2:0] CAT_W_C     = 3'd0;
  localparam logic [2:0] CAT_W_T     = 3'd1;
  localparam logic [2:0] CAT_W_OTHER = 3'd2;
  localparam logic [2:0] CAT_C_G     = 3'd3;
  localparam logic [2:0] CAT_C_A     = 3'd4;
  localparam logic [2:0] CAT_C_OTHER = 3'd5;

  // ascii bases
  localparam logic [7:0] CH_C_UP = 8'h43;
  localparam logic [7:0] CH_C_LO = 8'h63;
  localparam logic [7:0] CH_G_UP = 8'h47;
  localparam logic [7:0] CH_G_LO = 8'h67;
  localparam logic [7:0] CH_T_UP = 8'h54;
  localparam logic [7:0] CH_A_UP = 8'h41;

  // widest addresses over the parameter ranges
  localparam int SITE_AW_MAX = 20;
  localparam int BIAS_AW_MAX = 14;

  // decoupling queue
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  kind;
    logic        on_watson;
    logic [11:0] locus;
    logic [8:0]  read_cycle;
    logic [1:0]  bias_group;
    logic [7:0]  read_base;
    logic [7:0]  ref_first;
    logic [7:0]  ref_second;
    logic        pair_exists;
  } cmc_in_t;

  typedef struct packed {
    logic        counted;
    logic [2:0]  category;
    logic [31:0] count_w_c;
    logic [31:0] count_w_t;
    logic [31:0] count_w_other;
    logic [31:0] count_c_c;
    logic [31:0] count_c_t;
    logic [31:0] count_c_other;
  } cmc_out_t;

  // operation carried out by the back end
  typedef enum logic [1:0] {
    OP_ZERO    = 2'd0,
    OP_COUNT   = 2'd1,
    OP_SITE_RD = 2'd2,
    OP_BIAS_RD = 2'd3
  } cmc_op_e;

  typedef struct packed {
    cmc_op_e                op;
    logic [2:0]             category;
    logic                   bias_en;
    logic [SITE_AW_MAX-1:0] site_addr;
    logic [BIAS_AW_MAX-1:0] bias_addr;
  } cmc_op_t;

endpackage

/* src/cmc_ram.sv */
// ----------------------------------------------------------------------------
// cmc_ram
// Generic single-port-write, single-port-read memory with registered read.
// ----------------------------------------------------------------------------
module cmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/cmc_front.sv */
// ----------------------------------------------------------------------------
// cmc_front
// Input side: takes a beat, checks for a CpG, picks the count category and
// works out the site and bias addresses, then pushes one operation.
// ----------------------------------------------------------------------------
module cmc_front #(
  parameter int SITE_WINDOW  = 4096,
  parameter int MAX_READ_LEN = 512
) (
  input  logic             in_valid,
  output logic             in_ready,
  input  cmc_pkg::cmc_in_t in_data,
  input  logic             busy,
  input  logic             q_full,
  output logic             push,
  output cmc_pkg::cmc_op_t push_data
);
  import cmc_pkg::*;

  // locus reduced into the site window by shifted conditional subtracts
  function automatic logic [11:0] site_mod(input logic [11:0] v);
    logic [31:0] acc;
    acc = 32'(v);
    for (int k = 7; k >= 0; k--) begin
      if (acc >= (32'(SITE_WINDOW) << k)) begin
        acc = acc - (32'(SITE_WINDOW) << k);
      end
    end
    return acc[11:0];
  endfunction

  // read cycle reduced into the row range the same way
  function automatic logic [8:0] cyc_mod(input logic [8:0] v);
    logic [31:0] acc;
    acc = 32'(v);
    for (int k = 4; k >= 0; k--) begin
      if (acc >= (32'(MAX_READ_LEN) << k)) begin
        acc = acc - (32'(MAX_READ_LEN) << k);
      end
    end
    return acc[8:0];
  endfunction

  logic        is_cpg;
  logic [11:0] site_pos;
  logic [11:0] site_red;
  logic [8:0]  row;
  logic [31:0] bias_sum;
  logic        grp_ok;
  logic [2:0]  cat;

  // handshake
  assign in_ready = !q_full && !busy;
  assign push     = in_valid && in_ready;

  // cpg test on the reference pair
  assign is_cpg = in_data.pair_exists &&
                  (in_data.ref_first == CH_C_UP || in_data.ref_first == CH_C_LO) &&
                  (in_data.ref_second == CH_G_UP || in_data.ref_second == CH_G_LO);

  // site is j on watson, j-1 on crick; read-back uses locus as given
  assign site_pos = (in_data.kind == KIND_COUNT && !in_data.on_watson) ?
                    in_data.locus - 12'd1 : in_data.locus;
  assign site_red = site_mod(site_pos);

  // bias row address within the three stacked group tables
  assign row    = cyc_mod(in_data.read_cycle);
  assign grp_ok = in_data.bias_group != GRP_NONE;
  always_comb begin
    unique case (in_data.bias_group)
      2'd1:    bias_sum = 32'(MAX_READ_LEN) + 32'(row);
      2'd2:    bias_sum = 32'(2 * MAX_READ_LEN) + 32'(row);
      default: bias_sum = 32'(row);
    endcase
  end

  // count category from strand and read base
  always_comb begin
    if (in_data.on_watson) begin
      priority if (in_data.read_base == CH_C_UP) cat = CAT_W_C;
      else if (in_data.read_base == CH_T_UP)     cat = CAT_W_T;
      else                                       cat = CAT_W_OTHER;
    end else begin
      priority if (in_data.read_base == CH_G_UP) cat = CAT_C_G;
      else if (in_data.read_base == CH_A_UP)     cat = CAT_C_A;
      else                                       cat = CAT_C_OTHER;
    end
  end

  // operation built from the kind
  always_comb begin
    push_data.op        = OP_ZERO;
    push_data.category  = cat;
    push_data.bias_en   = grp_ok;
    push_data.site_addr = SITE_AW_MAX'(site_red);
    push_data.bias_addr = bias_sum[BIAS_AW_MAX-1:0];
    unique case (in_data.kind)
      KIND_COUNT: begin
        if (is_cpg && (in_data.on_watson || in_data.locus != 12'd0)) begin
          push_data.op = OP_COUNT;
        end
      end
      KIND_SITE_RD: push_data.op = OP_SITE_RD;
      KIND_BIAS_RD: begin
        if (grp_ok) begin
          push_data.op = OP_BIAS_RD;
        end
      end
      default: push_data.op = OP_ZERO;
    endcase
  end

endmodule

/* src/cmc_queue.sv */
// ----------------------------------------------------------------------------
// cmc_queue
// Short queue of classified operations between the front and back ends.
// ----------------------------------------------------------------------------
module cmc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cmc_pkg::cmc_op_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output cmc_pkg::cmc_op_t pop_data
);
  import cmc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmc_op_t       slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;

  assign full      = fill_r == CW'(QUEUE_DEPTH);
  assign pop_valid = fill_r != '0;
  assign pop_data  = slot_r[rd_ptr_r];

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CW'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/cmc_back.sv */
// ----------------------------------------------------------------------------
// cmc_back
// Back end: clears both counter memories after reset, then runs each queued
// operation: a count is a read-modify-write of the site row (and of the bias
// row when its group has one), a read-back only reads; each loads the result register.
// ----------------------------------------------------------------------------
module cmc_back #(
  parameter int SITE_WINDOW  = 4096,
  parameter int MAX_READ_LEN = 512,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  output logic              busy,
  input  logic              q_valid,
  input  cmc_pkg::cmc_op_t  q_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output cmc_pkg::cmc_out_t out_data
);
  import cmc_pkg::*;

  localparam int SITE_AW    = $clog2(SITE_WINDOW);
  localparam int BIAS_DEPTH = NUM_GROUPS * MAX_READ_LEN;
  localparam int BIAS_AW    = $clog2(BIAS_DEPTH);
  localparam int CLR_DEPTH  = (SITE_WINDOW > BIAS_DEPTH) ? SITE_WINDOW : BIAS_DEPTH;
  localparam int CLR_AW     = $clog2(CLR_DEPTH);
  localparam int RW         = NUM_CAT * COUNT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_UPD   = 3'b100
  } state_t;

  // saturating increment of one counter in a row
  function automatic logic [RW-1:0] bump(input logic [RW-1:0] r, input logic [2:0] cat);
    logic [RW-1:0]          res;
    logic [COUNT_WIDTH-1:0] c;
    res = r;
    for (int k = 0; k < NUM_CAT; k++) begin
      c = r[k*COUNT_WIDTH +: COUNT_WIDTH];
      if (cat == 3'(k) && c != CNT_MAX) begin
        res[k*COUNT_WIDTH +: COUNT_WIDTH] = c + COUNT_WIDTH'(1);
      end
    end
    return res;
  endfunction

  // result beat from a row of counters
  function automatic cmc_out_t pack_out(input logic cnt, input logic [2:0] cat,
                                        input logic [RW-1:0] r);
    cmc_out_t o;
    o.counted       = cnt;
    o.category      = cat;
    o.count_w_c     = 32'(r[0*COUNT_WIDTH +: COUNT_WIDTH]);
    o.count_w_t     = 32'(r[1*COUNT_WIDTH +: COUNT_WIDTH]);
    o.count_w_other = 32'(r[2*COUNT_WIDTH +: COUNT_WIDTH]);
    o.count_c_c     = 32'(r[3*COUNT_WIDTH +: COUNT_WIDTH]);
    o.count_c_t     = 32'(r[4*COUNT_WIDTH +: COUNT_WIDTH]);
    o.count_c_other = 32'(r[5*COUNT_WIDTH +: COUNT_WIDTH]);
    return o;
  endfunction

  state_t            state_r, state_nxt;
  logic [CLR_AW-1:0] clr_r, clr_nxt;
  cmc_op_t           cur_r;
  logic              out_valid_r, out_valid_nxt;
  cmc_out_t          out_data_r, out_data_nxt;

  logic [RW-1:0]      site_rdata, bias_rdata;
  logic [RW-1:0]      site_bumped, bias_bumped;
  logic               site_we, bias_we;
  logic [SITE_AW-1:0] site_waddr;
  logic [BIAS_AW-1:0] bias_waddr;
  logic [RW-1:0]      site_wdata, bias_wdata;
  logic               clr_last;

  assign busy      = state_r == ST_CLEAR;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign clr_last  = clr_r == CLR_AW'(CLR_DEPTH - 1);

  // take the next operation once the result register frees up
  assign pop = (state_r == ST_IDLE) && q_valid && (!out_valid_r || out_ready);

  assign site_bumped = bump(site_rdata, cur_r.category);
  assign bias_bumped = bump(bias_rdata, cur_r.category);

  // memory write port: clearing sweep or write-back of the bumped rows
  always_comb begin
    if (state_r == ST_CLEAR) begin
      site_we    = 32'(clr_r) < 32'(SITE_WINDOW);
      bias_we    = 32'(clr_r) < 32'(BIAS_DEPTH);
      site_waddr = clr_r[SITE_AW-1:0];
      bias_waddr = clr_r[BIAS_AW-1:0];
      site_wdata = '0;
      bias_wdata = '0;
    end else begin
      site_we    = (state_r == ST_UPD) && (cur_r.op == OP_COUNT);
      bias_we    = (state_r == ST_UPD) && (cur_r.op == OP_COUNT) && cur_r.bias_en;
      site_waddr = cur_r.site_addr[SITE_AW-1:0];
      bias_waddr = cur_r.bias_addr[BIAS_AW-1:0];
      site_wdata = site_bumped;
      bias_wdata = bias_bumped;
    end
  end

  // sequencing and result register
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + CLR_AW'(1);
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        unique case (cur_r.op)
          OP_COUNT:   out_data_nxt = pack_out(1'b1, cur_r.category, site_bumped);
          OP_SITE_RD: out_data_nxt = pack_out(1'b0, CAT_W_C, site_rdata);
          OP_BIAS_RD: out_data_nxt = pack_out(1'b0, CAT_W_C, bias_rdata);
          default:    out_data_nxt = '0;
        endcase
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (pop) begin
      cur_r <= q_data;
    end
  end

  // per-site counter rows
  cmc_ram #(
    .WIDTH (RW),
    .DEPTH (SITE_WINDOW)
  ) u_site_ram (
    .clk   (clk),
    .we    (site_we),
    .waddr (site_waddr),
    .wdata (site_wdata),
    .raddr (q_data.site_addr[SITE_AW-1:0]),
    .rdata (site_rdata)
  );

  // per-cycle bias counter rows, three groups stacked
  cmc_ram #(
    .WIDTH (RW),
    .DEPTH (BIAS_DEPTH)
  ) u_bias_ram (
    .clk   (clk),
    .we    (bias_we),
    .waddr (bias_waddr),
    .wdata (bias_wdata),
    .raddr (q_data.bias_addr[BIAS_AW-1:0]),
    .rdata (bias_rdata)
  );

endmodule

/* src/cpg_methylation_counter.sv */
// ----------------------------------------------------------------------------
// cpg_methylation_counter
// Counts CpG read bases per site and per read cycle with saturating counters,
// and returns a site's or a bias row's six counters on request.
//
//   channel | direction | payload   | handshake
//   in      | input     | cmc_in_t  | in_valid / in_ready
//   out     | output    | cmc_out_t | out_valid / out_ready
//
// After reset a clearing pass over max(SITE_WINDOW, 3*MAX_READ_LEN) addresses
// (4096 at the default sizes) zeroes both counter memories; in_ready is low.
// Each item then passes the back end's idle and update states: registered read
// of the counter memories, then write-back; no new item is taken meanwhile.
// A two-beat queue lets the input side keep accepting while a result waits.
// Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module cpg_methylation_counter #(
  parameter int SITE_WINDOW  = 4096,
  parameter int MAX_READ_LEN = 512,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cmc_pkg::cmc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cmc_pkg::cmc_out_t out_data
);
  import cmc_pkg::*;

  logic    busy;
  logic    q_full;
  logic    push;
  cmc_op_t push_data;
  logic    pop;
  logic    q_valid;
  cmc_op_t q_data;

  // classify incoming beats
  cmc_front #(
    .SITE_WINDOW  (SITE_WINDOW),
    .MAX_READ_LEN (MAX_READ_LEN)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .busy      (busy),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // decoupling queue
  cmc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  // counter memories and result register
  cmc_back #(
    .SITE_WINDOW  (SITE_WINDOW),
    .MAX_READ_LEN (MAX_READ_LEN),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .busy      (busy),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
